[rtl/core/sac_pkg.sv]
// Package for the stick axis conditioner: widths, constants and item types.
// Used by every module in rtl/core through scoped names; depends on nothing.

package sac_pkg;

  // Raw sample width; all datapath widths but the deadzone width follow from it.
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned OUT_W  = SAMPLE_BITS + 1;      // conditioned axis, +-1.0
  localparam int unsigned SUM_W  = SAMPLE_BITS + 2;      // axis plus key terms
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;      // x*x + y*y
  localparam int unsigned ROOT_W = SAMPLE_BITS;          // floor square root
  localparam int unsigned NUM_W  = 2 * SAMPLE_BITS - 1;  // |axis| * 1.0
  localparam int unsigned Q_W    = SAMPLE_BITS;          // normalized magnitude

  // Deadzone register has a fixed width.
  localparam int unsigned DZ_W  = 16;
  localparam int unsigned MAG_W = (OUT_W > DZ_W) ? OUT_W : DZ_W;
  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(1638);

  // Decoupling queue between front and back.
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic signed [SAMPLE_BITS-1:0] RAW_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ONE_SUM =
    {{(SUM_W-SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] ONE_OUT = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic [SQ_W-1:0]         sq;
    logic                    norm;
  } sac_item_t;

  // Item with its vector length, handed from the root unit to the divider.
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic [ROOT_W-1:0]       len;
    logic                    norm;
  } sac_len_t;

endpackage

[rtl/core/sac_front.sv]
// Front part of the stick axis conditioner: accepts items, scales, applies
// deadzone and keys, clamps, squares and classifies. Depends on sac_pkg.

module sac_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [sac_pkg::SAMPLE_BITS-1:0]   raw_x_i,
  input  logic signed [sac_pkg::SAMPLE_BITS-1:0]   raw_y_i,
  input  logic                                     key_left_i,
  input  logic                                     key_right_i,
  input  logic                                     key_up_i,
  input  logic                                     key_down_i,
  input  logic [sac_pkg::DZ_W-1:0]                 dz_i,
  output logic                                     item_valid_o,
  output sac_pkg::sac_item_t                       item_o,
  input  logic                                     item_ready_i
);

  function automatic logic signed [sac_pkg::OUT_W-1:0] cond_axis(
    input logic signed [sac_pkg::SAMPLE_BITS-1:0] raw,
    input logic [sac_pkg::DZ_W-1:0]               dz,
    input logic                                   key_neg,
    input logic                                   key_pos
  );
    logic signed [sac_pkg::OUT_W-1:0] s;
    logic [sac_pkg::OUT_W-1:0]        mag;
    logic signed [sac_pkg::SUM_W-1:0] v;
    // Linear map onto 1.0 = 2^(N-1): only the top code moves up by one.
    s = $signed({raw[sac_pkg::SAMPLE_BITS-1], raw}) +
        $signed({{(sac_pkg::OUT_W-1){1'b0}}, (raw == sac_pkg::RAW_MAX)});
    mag = s[sac_pkg::OUT_W-1] ? sac_pkg::OUT_W'(-s) : sac_pkg::OUT_W'(s);
    if (sac_pkg::MAG_W'(mag) < sac_pkg::MAG_W'(dz)) begin
      s = '0;
    end
    v = $signed({s[sac_pkg::OUT_W-1], s});
    if (key_pos) begin
      v = v + sac_pkg::ONE_SUM;
    end
    if (key_neg) begin
      v = v - sac_pkg::ONE_SUM;
    end
    if (v > sac_pkg::ONE_SUM) begin
      v = sac_pkg::ONE_SUM;
    end else if (v < -sac_pkg::ONE_SUM) begin
      v = -sac_pkg::ONE_SUM;
    end
    return $signed(v[sac_pkg::OUT_W-1:0]);
  endfunction

  logic                                 en;
  logic                                 s1_valid_q;
  logic signed [sac_pkg::OUT_W-1:0]     x1_q, y1_q;
  logic                                 s2_valid_q;
  sac_pkg::sac_item_t                   item_q, item_d;
  logic signed [2*sac_pkg::OUT_W-1:0]   px, py;

  // Advance both stages together unless the finished item is stuck.
  assign en      = !s2_valid_q || item_ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q   <= cond_axis(raw_x_i, dz_i, key_left_i, key_right_i);
      y1_q   <= cond_axis(raw_y_i, dz_i, key_up_i, key_down_i);
      item_q <= item_d;
    end
  end

  always_comb begin
    px          = x1_q * x1_q;
    py          = y1_q * y1_q;
    item_d.x    = x1_q;
    item_d.y    = y1_q;
    item_d.sq   = sac_pkg::SQ_W'(px) + sac_pkg::SQ_W'(py);
    // Length >= 1.0 when the sum reaches 2^(2N-2); the sum never exceeds 2^(2N-1).
    item_d.norm = item_d.sq[sac_pkg::SQ_W-1] | item_d.sq[sac_pkg::SQ_W-2];
  end

  assign item_valid_o = s2_valid_q;
  assign item_o       = item_q;

endmodule

[rtl/core/sac_queue.sv]
// Short item queue between the front and back of the stick axis conditioner.
// Depends on sac_pkg for the item type and depth.

module sac_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  sac_pkg::sac_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output sac_pkg::sac_item_t pop_item_o
);

  sac_pkg::sac_item_t               mem_q [sac_pkg::QUEUE_DEPTH];
  logic [sac_pkg::QUEUE_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [sac_pkg::QUEUE_AW:0]       count_q;
  logic                             push, pop;

  assign push_ready_o = (count_q != (sac_pkg::QUEUE_AW+1)'(sac_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/core/sac_sqrt.sv]
// Pipelined floor square root of x*x + y*y, one root bit per stage.
// Depends on sac_pkg; stalls as a whole on en_i.

module sac_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  sac_pkg::sac_item_t in_item_i,
  output logic               out_valid_o,
  output sac_pkg::sac_len_t  out_item_o
);

  localparam int unsigned STAGES = sac_pkg::ROOT_W;

  typedef struct packed {
    logic signed [sac_pkg::OUT_W-1:0] x;
    logic signed [sac_pkg::OUT_W-1:0] y;
    logic                             norm;
    logic [sac_pkg::SQ_W-1:0]         rem;
    logic [sac_pkg::ROOT_W-1:0]       root;
  } sqrt_stage_t;

  sqrt_stage_t st_q  [STAGES];
  logic        vld_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int unsigned B = STAGES - 1 - k;
    sqrt_stage_t              cur, nxt;
    logic                     cur_vld;
    logic [sac_pkg::SQ_W:0]   trial;

    if (k == 0) begin : g_first
      always_comb begin
        cur.x    = in_item_i.x;
        cur.y    = in_item_i.y;
        cur.norm = in_item_i.norm;
        cur.rem  = in_item_i.sq;
        cur.root = '0;
        cur_vld  = in_valid_i;
      end
    end else begin : g_next
      assign cur     = st_q[k-1];
      assign cur_vld = vld_q[k-1];
    end

    // Try setting root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
    always_comb begin
      trial = ((sac_pkg::SQ_W+1)'(cur.root) << (B + 1)) +
              ((sac_pkg::SQ_W+1)'(1) << (2 * B));
      nxt = cur;
      if ({1'b0, cur.rem} >= trial) begin
        nxt.rem  = cur.rem - trial[sac_pkg::SQ_W-1:0];
        nxt.root = cur.root | (sac_pkg::ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign out_valid_o     = vld_q[STAGES-1];
  assign out_item_o.x    = st_q[STAGES-1].x;
  assign out_item_o.y    = st_q[STAGES-1].y;
  assign out_item_o.len  = st_q[STAGES-1].root;
  assign out_item_o.norm = st_q[STAGES-1].norm;

endmodule

[rtl/core/sac_div.sv]
// Pipelined division of both axes by the vector length, one quotient bit
// per stage, plus the output register. Depends on sac_pkg.

module sac_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               in_valid_i,
  input  sac_pkg::sac_len_t                  in_item_i,
  output logic                               out_valid_o,
  output logic signed [sac_pkg::OUT_W-1:0]   out_x_o,
  output logic signed [sac_pkg::OUT_W-1:0]   out_y_o,
  output logic                               out_norm_o
);

  localparam int unsigned STAGES = sac_pkg::Q_W;

  typedef struct packed {
    logic signed [sac_pkg::OUT_W-1:0] x;
    logic signed [sac_pkg::OUT_W-1:0] y;
    logic                             norm;
    logic [sac_pkg::ROOT_W-1:0]       len;
    logic [sac_pkg::NUM_W-1:0]        rx;
    logic [sac_pkg::NUM_W-1:0]        ry;
    logic [sac_pkg::Q_W-1:0]          qx;
    logic [sac_pkg::Q_W-1:0]          qy;
  } div_stage_t;

  div_stage_t                       st_q  [STAGES];
  logic                             vld_q [STAGES];
  logic                             out_vld_q;
  logic signed [sac_pkg::OUT_W-1:0] out_x_q, out_y_q, res_x, res_y;
  logic                             out_norm_q;
  logic [sac_pkg::OUT_W-1:0]        mag_x, mag_y;

  // Numerator is |axis| * 1.0.
  assign mag_x = in_item_i.x[sac_pkg::OUT_W-1] ? sac_pkg::OUT_W'(-in_item_i.x)
                                               : sac_pkg::OUT_W'(in_item_i.x);
  assign mag_y = in_item_i.y[sac_pkg::OUT_W-1] ? sac_pkg::OUT_W'(-in_item_i.y)
                                               : sac_pkg::OUT_W'(in_item_i.y);

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int unsigned B = STAGES - 1 - k;
    div_stage_t                cur, nxt;
    logic                      cur_vld;
    logic [sac_pkg::NUM_W-1:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        cur.x    = in_item_i.x;
        cur.y    = in_item_i.y;
        cur.norm = in_item_i.norm;
        cur.len  = in_item_i.len;
        cur.rx   = sac_pkg::NUM_W'(mag_x) << (sac_pkg::SAMPLE_BITS - 1);
        cur.ry   = sac_pkg::NUM_W'(mag_y) << (sac_pkg::SAMPLE_BITS - 1);
        cur.qx   = '0;
        cur.qy   = '0;
        cur_vld  = in_valid_i;
      end
    end else begin : g_next
      assign cur     = st_q[k-1];
      assign cur_vld = vld_q[k-1];
    end

    always_comb begin
      trial = sac_pkg::NUM_W'(cur.len) << B;
      nxt   = cur;
      if (cur.rx >= trial) begin
        nxt.rx = cur.rx - trial;
        nxt.qx = cur.qx | (sac_pkg::Q_W'(1) << B);
      end
      if (cur.ry >= trial) begin
        nxt.ry = cur.ry - trial;
        nxt.qy = cur.qy | (sac_pkg::Q_W'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  // Restore signs, or pass the clamped pair when it stays inside the circle.
  always_comb begin
    res_x = st_q[STAGES-1].x;
    res_y = st_q[STAGES-1].y;
    if (st_q[STAGES-1].norm) begin
      res_x = $signed({1'b0, st_q[STAGES-1].qx});
      res_y = $signed({1'b0, st_q[STAGES-1].qy});
      if (st_q[STAGES-1].x[sac_pkg::OUT_W-1]) begin
        res_x = -res_x;
      end
      if (st_q[STAGES-1].y[sac_pkg::OUT_W-1]) begin
        res_y = -res_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_norm_q <= st_q[STAGES-1].norm;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_norm_o  = out_norm_q;

endmodule

[rtl/core/stick_axis_conditioner.sv]
// Stick axis conditioner: one item per cycle sustained when nothing stalls. An
// accepted item passes through two front stages, one queue slot, SAMPLE_BITS
// root stages, SAMPLE_BITS divider stages and the output register.
// Reset (rst_ni, async, active low) empties every stage and the queue and
// loads the deadzone register with 1638; datapath registers are not reset.

module stick_axis_conditioner (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // deadzone register write port
  input  logic                                   cfg_we_i,
  input  logic [sac_pkg::DZ_W-1:0]               cfg_wdata_i,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [sac_pkg::SAMPLE_BITS-1:0] raw_x_i,
  input  logic signed [sac_pkg::SAMPLE_BITS-1:0] raw_y_i,
  input  logic                                   key_left_i,
  input  logic                                   key_right_i,
  input  logic                                   key_up_i,
  input  logic                                   key_down_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sac_pkg::OUT_W-1:0]       out_x_o,
  output logic signed [sac_pkg::OUT_W-1:0]       out_y_o,
  output logic                                   was_normalized_o
);

  logic [sac_pkg::DZ_W-1:0] dz_q;

  // Front to queue.
  logic                     fr_valid;
  logic                     fr_ready;
  sac_pkg::sac_item_t       fr_item;

  // Queue to back.
  logic                     q_valid;
  sac_pkg::sac_item_t       q_item;

  // Back internals.
  logic                     back_en;
  logic                     rt_valid;
  sac_pkg::sac_len_t        rt_item;

  // Deadzone register; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= sac_pkg::DZ_RESET;
    end else if (cfg_we_i) begin
      dz_q <= cfg_wdata_i;
    end
  end

  // Front: accept, scale, deadzone, keys, clamp, square and classify.
  sac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .raw_x_i      (raw_x_i),
    .raw_y_i      (raw_y_i),
    .key_left_i   (key_left_i),
    .key_right_i  (key_right_i),
    .key_up_i     (key_up_i),
    .key_down_i   (key_down_i),
    .dz_i         (dz_q),
    .item_valid_o (fr_valid),
    .item_o       (fr_item),
    .item_ready_i (fr_ready)
  );

  // Queue: lets the front keep taking items while the back holds a result.
  sac_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (back_en),
    .pop_item_o   (q_item)
  );

  // Back: advance every stage together unless the output item waits.
  assign back_en = !out_valid_o || out_ready_i;

  sac_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (back_en),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .out_valid_o (rt_valid),
    .out_item_o  (rt_item)
  );

  sac_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (back_en),
    .in_valid_i  (rt_valid),
    .in_item_i   (rt_item),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_norm_o  (was_normalized_o)
  );

  // A vector scaled onto the unit circle is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_normalized_o |-> (out_x_o != '0 || out_y_o != '0))
    else $error("normalized result is the zero vector");

  // A pair left as is lies strictly inside the circle, so no axis is +-1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_normalized_o |->
      (out_x_o != sac_pkg::ONE_OUT && out_x_o != -sac_pkg::ONE_OUT &&
       out_y_o != sac_pkg::ONE_OUT && out_y_o != -sac_pkg::ONE_OUT))
    else $error("unnormalized result reaches the unit circle");

  // Hold the root unit's output while the back is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_valid && !back_en |=> rt_valid && $stable(rt_item))
    else $error("root stage item lost during stall");

  // Hold the queue head while the back is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !back_en |=> q_valid && $stable(q_item))
    else $error("queue head lost during stall");

endmodule
